/* design/mdtr_pkg.sv */
// mdtr_pkg: shared constants, codes and types of the mesh destination table router
// no dependencies; imported by every module of the block
`default_nettype none

package mdtr_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int ADDR_W      = 16;
    localparam int THING_W     = 16;
    localparam int INST_W      = 8;
    localparam int KEY_W       = THING_W + INST_W;
    localparam int CMD_W       = 4;
    localparam int ROLE_W      = 2;
    localparam int PHASE_W     = 2;
    localparam int DISP_W      = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 24;

    // commands
    localparam logic [CMD_W-1:0] CMD_READY     = 4'd0;
    localparam logic [CMD_W-1:0] CMD_LOST      = 4'd1;
    localparam logic [CMD_W-1:0] CMD_ADD_LOCAL = 4'd2;
    localparam logic [CMD_W-1:0] CMD_ADD_REM   = 4'd3;
    localparam logic [CMD_W-1:0] CMD_TICK      = 4'd4;
    localparam logic [CMD_W-1:0] CMD_ACK       = 4'd5;
    localparam logic [CMD_W-1:0] CMD_FAILURE   = 4'd6;
    localparam logic [CMD_W-1:0] CMD_CLASSIFY  = 4'd7;
    localparam logic [CMD_W-1:0] CMD_NEXT_HOP  = 4'd8;

    // node roles
    localparam logic [ROLE_W-1:0] ROLE_LEADER = 2'd1;
    localparam logic [ROLE_W-1:0] ROLE_JOINER = 2'd2;

    // announce phases
    localparam logic [PHASE_W-1:0] PHASE_IDLE  = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_READY = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_WAIT  = 2'd2;

    // classify results
    localparam logic [DISP_W-1:0] DISP_LOCAL   = 2'd0;
    localparam logic [DISP_W-1:0] DISP_FORWARD = 2'd1;
    localparam logic [DISP_W-1:0] DISP_DROP    = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEADER = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic load;     // capture the incoming transaction
        logic compare;  // parallel key compare into match vector
        logic exec;     // update state and write the result register
    } t_dp_cmd;

    typedef struct packed {
        logic [PHASE_W-1:0] announce_phase;
        logic               table_full;
        logic               network_ready;
        logic               announce_request;
        logic               found;
        logic [ADDR_W-1:0]  next_hop;
        logic [DISP_W-1:0]  disposition;
    } t_result;

endpackage

`default_nettype wire

/* design/mdtr_ctrl.sv */
// mdtr_ctrl: controller state machine sequencing load, compare and execute
// depends on mdtr_pkg for the datapath command struct
`default_nettype none

module mdtr_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_s_valid,
    output logic              o_s_ready,
    output logic              o_m_valid,
    input  wire               i_m_ready,
    output mdtr_pkg::t_dp_cmd o_cmd
);
    import mdtr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || i_m_ready;
    assign o_s_ready   = (r_state == S_IDLE);
    assign o_m_valid   = r_out_valid;

    assign o_cmd.load    = (r_state == S_IDLE) && i_s_valid;
    assign o_cmd.compare = (r_state == S_CMP);
    // execute waits until the result register can take a new result
    assign o_cmd.exec    = (r_state == S_EXEC) && w_out_free;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_m_ready;
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) n_state = S_CMP;
            end
            S_CMP: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

/* design/mdtr_datapath.sv */
// mdtr_datapath: destination table, config registers, announce state and result register
// depends on mdtr_pkg for constants, command codes and the result struct
`default_nettype none

module mdtr_datapath (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  mdtr_pkg::t_dp_cmd              i_cmd,
    input  wire                            i_cfg_we,
    input  wire [mdtr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [mdtr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire [mdtr_pkg::CMD_W-1:0]      i_command,
    input  wire [mdtr_pkg::THING_W-1:0]    i_thing,
    input  wire [mdtr_pkg::INST_W-1:0]     i_instance_id,
    input  wire [mdtr_pkg::ADDR_W-1:0]     i_origin_address,
    input  wire                            i_send_accepted,
    output mdtr_pkg::t_result              o_res
);
    import mdtr_pkg::*;

    // configuration
    logic [ROLE_W-1:0]  r_role;
    logic [ADDR_W-1:0]  r_own_addr;
    logic [ADDR_W-1:0]  r_leader_addr;

    // captured transaction
    logic [CMD_W-1:0]   r_cmd;
    logic [KEY_W-1:0]   r_key;
    logic [ADDR_W-1:0]  r_origin;
    logic               r_accepted;

    // table
    logic [KEY_W-1:0]       r_ent_key   [TABLE_DEPTH];
    logic [ADDR_W-1:0]      r_ent_owner [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_ent_local;
    logic [TABLE_DEPTH-1:0] r_ent_valid, n_ent_valid;

    // compare stage
    logic [TABLE_DEPTH-1:0] r_match;
    logic [TABLE_DEPTH-1:0] n_match;

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic               r_ready, n_ready;
    t_result            r_res, n_res;

    logic                   w_hit;
    logic                   w_hit_local;
    logic [ADDR_W-1:0]      w_hit_owner;
    logic [TABLE_DEPTH-1:0] w_free;
    logic [TABLE_DEPTH-1:0] w_free_first;
    logic [TABLE_DEPTH-1:0] w_wr_en;
    logic [ADDR_W-1:0]      w_wr_owner;
    logic                   w_wr_local;

    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            n_match[i] = r_ent_valid[i] && (r_ent_key[i] == r_key);
        end
    end

    // keys are unique among valid entries, so the match vector is one-hot or zero
    always_comb begin
        w_hit_owner = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_hit_owner = w_hit_owner | (r_ent_owner[i] & {ADDR_W{r_match[i]}});
        end
    end

    assign w_hit        = |r_match;
    assign w_hit_local  = |(r_match & r_ent_local);
    assign w_free       = ~r_ent_valid;
    // lowest free slot
    assign w_free_first = w_free & (~w_free + {{(TABLE_DEPTH-1){1'b0}}, 1'b1});

    always_comb begin
        n_phase     = r_phase;
        n_ready     = r_ready;
        n_ent_valid = r_ent_valid;
        w_wr_en     = '0;
        w_wr_owner  = r_own_addr;
        w_wr_local  = 1'b1;
        n_res       = '0;
        case (r_cmd)
            CMD_READY: begin
                n_ent_valid = '0;
                n_ready     = (r_role == ROLE_LEADER);
                n_phase     = (r_role == ROLE_JOINER) ? PHASE_READY : PHASE_IDLE;
            end
            CMD_LOST: begin
                n_ent_valid = '0;
                n_ready     = 1'b0;
                n_phase     = PHASE_IDLE;
            end
            CMD_ADD_LOCAL, CMD_ADD_REM: begin
                if (r_cmd == CMD_ADD_REM) begin
                    w_wr_owner = r_origin;
                    w_wr_local = 1'b0;
                end
                if (r_cmd == CMD_ADD_LOCAL || r_role == ROLE_LEADER) begin
                    if (w_hit) begin
                        w_wr_en = r_match;
                    end else if (|w_free) begin
                        w_wr_en     = w_free_first;
                        n_ent_valid = r_ent_valid | w_free_first;
                    end else begin
                        n_res.table_full = 1'b1;
                    end
                end
            end
            CMD_TICK: begin
                if (r_role == ROLE_JOINER && r_phase == PHASE_READY) begin
                    n_res.announce_request = 1'b1;
                    if (r_accepted) n_phase = PHASE_WAIT;
                end
            end
            CMD_ACK: begin
                n_phase = PHASE_IDLE;
                n_ready = 1'b1;
            end
            CMD_FAILURE: begin
                n_phase = PHASE_READY;
            end
            CMD_CLASSIFY: begin
                if (r_role == ROLE_JOINER) begin
                    n_res.disposition = DISP_LOCAL;
                end else if (r_role != ROLE_LEADER || !w_hit) begin
                    n_res.disposition = DISP_DROP;
                end else if (w_hit_local) begin
                    n_res.disposition = DISP_LOCAL;
                end else begin
                    n_res.disposition = DISP_FORWARD;
                    n_res.found       = 1'b1;
                    n_res.next_hop    = w_hit_owner;
                end
            end
            CMD_NEXT_HOP: begin
                if (r_role == ROLE_JOINER) begin
                    n_res.next_hop = r_leader_addr;
                    n_res.found    = (r_leader_addr != '0);
                end else if (r_role == ROLE_LEADER && w_hit) begin
                    n_res.next_hop = w_hit_owner;
                    n_res.found    = 1'b1;
                end
            end
            default: begin
            end
        endcase
        n_res.network_ready  = n_ready;
        n_res.announce_phase = n_phase;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_role        <= '0;
            r_own_addr    <= '0;
            r_leader_addr <= '0;
            r_ent_valid   <= '0;
            r_phase       <= PHASE_IDLE;
            r_ready       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ROLE:   r_role        <= i_cfg_data[ROLE_W-1:0];
                    CFG_OWN:    r_own_addr    <= i_cfg_data[ADDR_W-1:0];
                    CFG_LEADER: r_leader_addr <= i_cfg_data[ADDR_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.exec) begin
                r_ent_valid <= n_ent_valid;
                r_phase     <= n_phase;
                r_ready     <= n_ready;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd      <= i_command;
            r_key      <= {i_thing, i_instance_id};
            r_origin   <= i_origin_address;
            r_accepted <= i_send_accepted;
        end
        if (i_cmd.compare) begin
            r_match <= n_match;
        end
        if (i_cmd.exec) begin
            r_res <= n_res;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (w_wr_en[i]) begin
                    r_ent_key[i]   <= r_key;
                    r_ent_owner[i] <= w_wr_owner;
                    r_ent_local[i] <= w_wr_local;
                end
            end
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

/* design/mesh_destination_table_router_core.sv */
// mesh destination table router, top level
// - input stream s_axis carries one command transaction; output stream m_axis
//   returns exactly one result transaction per command, in order
// - configuration: i_cfg_we writes register i_cfg_index (0 role, 1 own address,
//   2 leader address) with i_cfg_data at the clock edge; write only while idle
// - steps: a command accepted on s_axis is captured, then a parallel key compare
//   runs over the 32-entry register table, then execute with table update writes
//   the result to m_axis once the output is free
// - s_axis_tready is high only while the sequencer is idle; one command is in
//   work at a time
// - a waiting result sits in the output register; a new command is accepted
//   meanwhile, and its execute step holds until m_axis_tready frees that register
// - reset (i_rst_n low, synchronous) clears the table valid bits, announce phase,
//   ready flag, configuration registers and any pending result
// depends on mdtr_pkg, mdtr_ctrl, mdtr_datapath
`default_nettype none

module mesh_destination_table_router_core (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    // command[3:0], thing[19:4], instance_id[27:20], origin_address[43:28],
    // send_accepted[44], zero[47:45]
    input  wire [mdtr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready,
    // disposition[1:0], next_hop[17:2], found[18], announce_request[19],
    // network_ready[20], table_full[21], announce_phase[23:22]
    output logic [mdtr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  wire                            i_cfg_we,
    input  wire [mdtr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [mdtr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mdtr_pkg::*;

    t_dp_cmd w_cmd;
    t_result w_res;

    mdtr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_cmd     (w_cmd)
    );

    mdtr_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_command        (s_axis_tdata[3:0]),
        .i_thing          (s_axis_tdata[19:4]),
        .i_instance_id    (s_axis_tdata[27:20]),
        .i_origin_address (s_axis_tdata[43:28]),
        .i_send_accepted  (s_axis_tdata[44]),
        .o_res            (w_res)
    );

    assign m_axis_tdata = w_res;

endmodule

`default_nettype wire

/* design/mdtr_checker.sv */
// mdtr_checker: port-level assertions for the router top level, with bind
// depends on mdtr_pkg for port widths
`default_nettype none

module mdtr_checker (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            s_axis_tvalid,
    input wire                            s_axis_tready,
    input wire [mdtr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input wire                            m_axis_tvalid,
    input wire                            m_axis_tready,
    input wire [mdtr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input wire                            i_cfg_we,
    input wire [mdtr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input wire [mdtr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mdtr_pkg::*;

    // a stalled result keeps valid and data
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result dropped or changed");

    // one command in work at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second command accepted while busy");

    // a result never appears in the cycle right after its command
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result appeared too early");

    // the compare step always follows capture, so ready is still low when the execute step starts
    a_busy_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> ##1 !s_axis_tready)
        else $error("command sequence shorter than three cycles");

    // reset leaves no pending result
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind mesh_destination_table_router_core mdtr_checker u_mdtr_checker (.*);

`default_nettype wire
